// ===== design/bounded_undo_redo_history_macros.svh =====
// Assertion macros for the undo/redo history checker.
// No dependencies; included by burh_checker.sv.
`ifndef BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH
`define BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BURH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("burh assertion failed");

// Next-cycle implication, disabled during reset.
`define BURH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("burh assertion failed");

`endif

// ===== design/burh_pkg.sv =====
// Shared types and constants for the bounded undo/redo history.
// No dependencies.
`default_nettype none

package burh_pkg;

    localparam int FIELD_WIDTH       = 64;
    localparam int DEF_HISTORY_DEPTH = 16;
    localparam int DEF_ENTRY_WIDTH   = 64;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_UNDO = 2'd1,
        CMD_REDO = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECTED = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

`default_nettype wire

// ===== design/burh_cmd_if.sv =====
// Command channel: valid/ready with one command beat.
// Depends on burh_pkg.
`default_nettype none

interface burh_cmd_if
    import burh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [FIELD_WIDTH-1:0] entry_data;
    logic                   entry_committed;

    modport source (output valid, output command, output entry_data,
                    output entry_committed, input ready);
    modport sink   (input valid, input command, input entry_data,
                    input entry_committed, output ready);
endinterface

`default_nettype wire

// ===== design/burh_res_if.sv =====
// Result channel: valid/ready with one result beat.
// Depends on burh_pkg.
`default_nettype none

interface burh_res_if
    import burh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [FIELD_WIDTH-1:0] entry_out;

    modport source (output valid, output status, output entry_out, input ready);
    modport sink   (input valid, input status, input entry_out, output ready);
endinterface

`default_nettype wire

// ===== design/burh_cell.sv =====
// One storage cell of a shift chain: loads from its left neighbor on push,
// from its right neighbor on pop. Depends on burh_pkg.
`default_nettype none

module burh_cell
    import burh_pkg::*;
#(
    parameter int WIDTH = DEF_ENTRY_WIDTH
) (
    input  wire logic             clk,
    input  wire shift_ctrl_t      ctrl,
    input  wire logic [WIDTH-1:0] from_prev,
    input  wire logic [WIDTH-1:0] from_next,
    output logic      [WIDTH-1:0] data
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        priority if (ctrl.push)
        begin
            data_next = from_prev;
        end
        else if (ctrl.pop)
        begin
            data_next = from_next;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== design/burh_chain.sv =====
// Row of cells forming a stack; cell 0 is the top, the far end drops off
// on push. Depends on burh_pkg and burh_cell.
`default_nettype none

module burh_chain
    import burh_pkg::*;
#(
    parameter int DEPTH = DEF_HISTORY_DEPTH,
    parameter int WIDTH = DEF_ENTRY_WIDTH
) (
    input  wire logic             clk,
    input  wire shift_ctrl_t      ctrl,
    input  wire logic [WIDTH-1:0] push_data,
    output logic      [WIDTH-1:0] top_data
);

    logic [WIDTH-1:0] cell_data [DEPTH];
    logic [WIDTH-1:0] cell_prev [DEPTH];
    logic [WIDTH-1:0] cell_next [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_prev[i] = push_data;
        end
        else
        begin : g_mid
            assign cell_prev[i] = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign cell_next[i] = cell_data[i];
        end
        else
        begin : g_inner
            assign cell_next[i] = cell_data[i+1];
        end

        burh_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .from_prev (cell_prev[i]),
            .from_next (cell_next[i]),
            .data      (cell_data[i])
        );
    end

    assign top_data = cell_data[0];

endmodule

`default_nettype wire

// ===== design/bounded_undo_redo_history.sv =====
// Bounded undo/redo history, top level.
// Depends on burh_pkg, burh_cmd_if, burh_res_if, burh_chain.
//
// Use: commands arrive on cmd (valid/ready), one result beat per command
// leaves on res. A push stores entry_data when entry_committed is set, and
// clears the redo side; undo and redo return the entry crossed by the cursor
// or status "empty".
// Entries live in two shift chains of cells: the undo stack (entries before
// the cursor, newest at cell 0) and the redo stack (entries after it). Undo
// moves the top of the undo chain to the redo chain, redo the reverse. A push
// into a full history lets the oldest entry fall off the end of the undo chain.
// Result: registered, valid in the cycle after the command beat.
// Throughput: one command per cycle unless res stalls; each command is at most
// one chain shift and a counter update, the output register the only buffer.
// Stall: while res is held off the result register keeps its beat and cmd
// ready stays low; ready returns in the cycle the result is taken.
// Reset: rst_n clears both counts and the result valid; cell contents are not
// cleared, and empty cells are never read.
`default_nettype none

module bounded_undo_redo_history
    import burh_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int ENTRY_WIDTH   = DEF_ENTRY_WIDTH
) (
    input wire logic   clk,
    input wire logic   rst_n,
    burh_cmd_if.sink   cmd,
    burh_res_if.source res
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [CW-1:0]          undo_cnt_reg, undo_cnt_next;
    logic [CW-1:0]          redo_cnt_reg, redo_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic [FIELD_WIDTH-1:0] entry_reg, entry_next;

    shift_ctrl_t            undo_ctrl, redo_ctrl;
    logic [ENTRY_WIDTH-1:0] undo_push_data, redo_push_data;
    logic [ENTRY_WIDTH-1:0] undo_top, redo_top;
    logic                   accept;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign redo_push_data = undo_top;

    always_comb
    begin
        undo_cnt_next  = undo_cnt_reg;
        redo_cnt_next  = redo_cnt_reg;
        undo_ctrl      = '0;
        redo_ctrl      = '0;
        undo_push_data = redo_top;
        status_next    = ST_OK;
        entry_next     = '0;

        unique case (cmd.command)
            CMD_PUSH:
            begin
                undo_push_data = cmd.entry_data[ENTRY_WIDTH-1:0];
                if (!cmd.entry_committed)
                begin
                    status_next = ST_REJECTED;
                end
                else
                begin
                    undo_ctrl.push = accept;
                    if (accept)
                    begin
                        redo_cnt_next = '0;
                        if (undo_cnt_reg != CW'(HISTORY_DEPTH))
                        begin
                            undo_cnt_next = undo_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            CMD_UNDO:
            begin
                if (undo_cnt_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    entry_next     = FIELD_WIDTH'(undo_top);
                    undo_ctrl.pop  = accept;
                    redo_ctrl.push = accept;
                    if (accept)
                    begin
                        undo_cnt_next = undo_cnt_reg - 1'b1;
                        redo_cnt_next = redo_cnt_reg + 1'b1;
                    end
                end
            end
            CMD_REDO:
            begin
                if (redo_cnt_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    entry_next     = FIELD_WIDTH'(redo_top);
                    redo_ctrl.pop  = accept;
                    undo_ctrl.push = accept;
                    if (accept)
                    begin
                        redo_cnt_next = redo_cnt_reg - 1'b1;
                        undo_cnt_next = undo_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            undo_cnt_reg  <= '0;
            redo_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            undo_cnt_reg  <= undo_cnt_next;
            redo_cnt_reg  <= redo_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
        end
    end

    burh_chain #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_undo_chain (
        .clk       (clk),
        .ctrl      (undo_ctrl),
        .push_data (undo_push_data),
        .top_data  (undo_top)
    );

    burh_chain #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_redo_chain (
        .clk       (clk),
        .ctrl      (redo_ctrl),
        .push_data (redo_push_data),
        .top_data  (redo_top)
    );

    assign res.valid     = out_valid_reg;
    assign res.status    = status_reg;
    assign res.entry_out = entry_reg;

endmodule

`default_nettype wire

// ===== design/burh_checker.sv =====
// Port-level checks for the undo/redo history, bound to the top level.
// Depends on burh_pkg and bounded_undo_redo_history_macros.svh.
`default_nettype none
`include "bounded_undo_redo_history_macros.svh"

module burh_checker
    import burh_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [1:0]             status,
    input wire logic [FIELD_WIDTH-1:0] entry_out
);

    `BURH_ASSERT_NEXT(a_beat_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
    `BURH_ASSERT_IMPLY(a_no_entry_on_fail, clk, rst_n,
        out_valid && (status == ST_REJECTED || status == ST_EMPTY), entry_out == '0)
    `BURH_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid,
        status == ST_OK || status == ST_REJECTED || status == ST_EMPTY)
    `BURH_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(entry_out))

endmodule

bind bounded_undo_redo_history burh_checker u_burh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (res.status),
    .entry_out (res.entry_out)
);

`default_nettype wire
